// ===== rtl/wsfb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package wsfb_pkg;

  localparam logic [31:0] KeyInit   = 32'hf1c3_7166;
  localparam logic [31:0] KeyXor    = 32'hf24d_6ade;
  localparam logic [6:0]  LenDirect = 7'd125;
  localparam logic [6:0]  LenCode16 = 7'd126;
  localparam logic [6:0]  LenCode64 = 7'd127;
  localparam logic [31:0] LenMax16  = 32'h0000_ffff;

  localparam int unsigned QAddrW = 2;
  localparam int unsigned QDepth = 1 << QAddrW;

  typedef enum logic {
    CMD_HEADER  = 1'b0,
    CMD_PAYLOAD = 1'b1
  } cmd_kind_e;

  // one queued command; a payload command carries its finished byte in head
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  head;
    logic [6:0]  code;
    logic        msk;
    logic [31:0] len;
    logic [31:0] key;
  } cmd_t;

  function automatic logic [7:0] sel_byte(input logic [31:0] w, input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0: b = w[7:0];
      2'd1: b = w[15:8];
      2'd2: b = w[23:16];
      default: b = w[31:24];
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/wsfb_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wsfb_front import wsfb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic        mode_i,
  input  wire logic [7:0]  head_byte_i,
  input  wire logic [31:0] payload_length_i,
  input  wire logic        mask_enable_i,
  input  wire logic [7:0]  payload_byte_i,
  output cmd_t             cmd_o
);

  logic [31:0] key_q, key_d;
  logic        mon_q, mon_d;
  logic [1:0]  kpos_q, kpos_d;
  logic [31:0] key_x;
  logic [31:0] key_next;
  logic [7:0]  pay_byte;

  assign key_x    = key_q ^ KeyXor;
  // times 31 as one shift and subtract
  assign key_next = {key_x[26:0], 5'b0} - key_x;
  assign pay_byte = payload_byte_i ^ (mon_q ? sel_byte(key_q, kpos_q) : 8'h00);

  always_comb begin
    key_d  = key_q;
    mon_d  = mon_q;
    kpos_d = kpos_q;
    cmd_o  = '0;
    if (mode_i == CMD_PAYLOAD) begin
      cmd_o.kind = CMD_PAYLOAD;
      cmd_o.head = pay_byte;
      kpos_d     = kpos_q + 2'd1;
    end else begin
      cmd_o.kind = CMD_HEADER;
      cmd_o.head = head_byte_i;
      cmd_o.msk  = mask_enable_i;
      cmd_o.len  = payload_length_i;
      cmd_o.key  = key_next;
      priority if (payload_length_i <= {25'd0, LenDirect}) begin
        cmd_o.code = payload_length_i[6:0];
      end else if (payload_length_i <= LenMax16) begin
        cmd_o.code = LenCode16;
      end else begin
        cmd_o.code = LenCode64;
      end
      if (mask_enable_i) key_d = key_next;
      mon_d  = mask_enable_i;
      kpos_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= KeyInit;
      mon_q  <= 1'b0;
      kpos_q <= 2'd0;
    end else if (accept_i) begin
      key_q  <= key_d;
      mon_q  <= mon_d;
      kpos_q <= kpos_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wsfb_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wsfb_queue import wsfb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_i,
  input  cmd_t      wr_cmd_i,
  output logic      full_o,
  input  wire logic rd_i,
  output cmd_t      rd_cmd_o,
  output logic      valid_o
);

  cmd_t              mem_q [QDepth];
  logic [QAddrW-1:0] wptr_q, rptr_q;
  logic [QAddrW:0]   cnt_q;
  logic              do_wr, do_rd;

  assign full_o   = (cnt_q == (QAddrW+1)'(QDepth));
  assign valid_o  = (cnt_q != '0);
  assign do_wr    = wr_i && !full_o;
  assign do_rd    = rd_i && valid_o;
  assign rd_cmd_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wr_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= wptr_q + 1'b1;
      if (do_rd) rptr_q <= rptr_q + 1'b1;
      priority if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wsfb_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wsfb_back import wsfb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  cmd_t             cmd_i,
  input  wire logic        cmd_valid_i,
  output logic             cmd_pop_o,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic [7:0]       out_byte_o,
  output logic             is_header_o,
  output logic             last_o
);

  logic [3:0] idx_q, idx_d;
  logic       ov_q;
  logic [7:0] byte_q;
  logic       hdr_q, last_q;

  logic       slot_free, fire;
  logic [3:0] ext, total, e, k;
  logic [7:0] hbyte, nbyte;
  logic       nlast, nhdr;

  assign slot_free = !ov_q || pop_i;
  assign fire      = cmd_valid_i && slot_free;

  always_comb begin
    unique case (cmd_i.code)
      LenCode16: ext = 4'd2;
      LenCode64: ext = 4'd8;
      default:   ext = 4'd0;
    endcase
    total = 4'd2 + ext + (cmd_i.msk ? 4'd4 : 4'd0);
    e     = idx_q - 4'd2;
    k     = e - ext;
    priority if (idx_q == 4'd0) begin
      hbyte = cmd_i.head;
    end else if (idx_q == 4'd1) begin
      hbyte = {cmd_i.msk, cmd_i.code};
    end else if (e < ext) begin
      if (cmd_i.code == LenCode16) begin
        hbyte = e[0] ? cmd_i.len[7:0] : cmd_i.len[15:8];
      end else if (e < 4'd4) begin
        hbyte = 8'h00;
      end else begin
        hbyte = sel_byte(cmd_i.len, ~e[1:0]);
      end
    end else begin
      hbyte = sel_byte(cmd_i.key, k[1:0]);
    end
    if (cmd_i.kind == CMD_PAYLOAD) begin
      nbyte = cmd_i.head;
      nhdr  = 1'b0;
      nlast = 1'b1;
    end else begin
      nbyte = hbyte;
      nhdr  = 1'b1;
      nlast = (idx_q == total - 4'd1);
    end
    idx_d = idx_q;
    if (fire) idx_d = nlast ? 4'd0 : idx_q + 4'd1;
  end

  assign cmd_pop_o = fire && nlast;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 4'd0;
      ov_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (slot_free) ov_q <= cmd_valid_i;
    end
  end

  // hold the shown beat until it is taken
  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= nbyte;
      hdr_q  <= nhdr;
      last_q <= nlast;
    end
  end

  assign empty_o     = !ov_q;
  assign out_byte_o  = byte_q;
  assign is_header_o = hdr_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

// ===== rtl/websocket_frame_builder.sv =====
// An accepted item is written into the command queue; its result bytes are then
// registered in the output slot. The serializer gives one result beat per cycle while
// pop takes them; a payload item is one beat, a header item 2 to 14 (one per byte).
// A four-entry command queue lets input run ahead of a stalled output.
// Reset (async, active low) clears the key to its seed, masking off, queue empty.
`timescale 1ns / 1ps
`default_nettype none
module websocket_frame_builder import wsfb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        mode_i,
  input  wire logic [7:0]  head_byte_i,
  input  wire logic [31:0] payload_length_i,
  input  wire logic        mask_enable_i,
  input  wire logic [7:0]  payload_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte_o,
  output logic             is_header_o,
  output logic             last_o
);

  cmd_t front_cmd, q_cmd;
  logic accept, q_valid, q_pop;

  assign accept = push && !full;

  wsfb_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i         (accept),
    .mode_i,
    .head_byte_i,
    .payload_length_i,
    .mask_enable_i,
    .payload_byte_i,
    .cmd_o            (front_cmd)
  );

  wsfb_queue u_queue (
    .clk_i,
    .rst_ni,
    .wr_i     (push),
    .wr_cmd_i (front_cmd),
    .full_o   (full),
    .rd_i     (q_pop),
    .rd_cmd_o (q_cmd),
    .valid_o  (q_valid)
  );

  wsfb_back u_back (
    .clk_i,
    .rst_ni,
    .cmd_i       (q_cmd),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (q_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_byte_o,
    .is_header_o,
    .last_o
  );

endmodule
`default_nettype wire

// ===== rtl/wsfb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module wsfb_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte_o,
  input wire logic       is_header_o,
  input wire logic       last_o
);

  // a stalled beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(is_header_o)
                          && $stable(last_o)))
    else $error("stalled result beat changed");

  // a payload beat always closes its item
  a_pay_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !is_header_o) |-> last_o)
    else $error("payload beat without last");

  // a header burst is never cut by a payload beat
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && is_header_o && !last_o) |=> (empty || is_header_o))
    else $error("header burst interrupted");

  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result shown during reset");

endmodule

bind websocket_frame_builder wsfb_checker u_wsfb_checker (
  .clk_i,
  .rst_ni,
  .empty,
  .pop,
  .out_byte_o,
  .is_header_o,
  .last_o
);
`default_nettype wire
